// File: rtl/ipv4dt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 dotted text parser package
// Character codes, parse phases, error codes and small helper functions.
// ----------------------------------------------------------------------------
package ipv4dt_pkg;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0b;
   localparam logic [7:0] CHAR_FFEED   = 8'h0c;
   localparam logic [7:0] CHAR_CRET    = 8'h0d;

   localparam logic [2:0] OCTETS_PER_ADDR = 3'd4;
   localparam logic [2:0] LAST_OCTET_IDX  = 3'd3;

   typedef enum logic [3:0] {
      PH_NUM_EXPECTED = 4'b0001,
      PH_IN_NUMBER    = 4'b0010,
      PH_DOT_EXPECTED = 4'b0100,
      PH_COMPLETE     = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_BAD_CHAR = 3'd1,
      ERR_NUM_EXP  = 3'd2,
      ERR_DOT_EXP  = 3'd3,
      ERR_SHORT    = 3'd4
   } error_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VTAB) ||
             (c == CHAR_FFEED) || (c == CHAR_CRET);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // value * 10 + digit, modulo 256
   function automatic logic [7:0] acc_digit(input logic [7:0] value,
                                            input logic [7:0] c);
      logic [7:0] digit;
      digit = c - CHAR_ZERO;
      return {value[4:0], 3'b000} + {value[6:0], 1'b0} + digit;
   endfunction

   // place an octet into its slot, first octet in the top byte
   function automatic logic [31:0] put_octet(input logic [31:0] addr,
                                             input logic [1:0]  slot,
                                             input logic [7:0]  octet);
      logic [31:0] res;
      res = addr;
      case (slot)
         2'd0:    res[31:24] = octet;
         2'd1:    res[23:16] = octet;
         2'd2:    res[15:8]  = octet;
         default: res[7:0]   = octet;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/ipv4_dotted_text_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 dotted text parser
// Parses lines of dotted-decimal IPv4 text, one character word at a time.
// ----------------------------------------------------------------------------
// One character word enters per cycle. Each word is held in an input
// register, then a single step of parse logic updates the line state;
// a newline loads the result register with the address and error code and
// clears the line state. Throughput is one word per cycle; a newline reaches
// rsp_valid via the input and result registers, other words produce no result.
// Blanks (space, tab, vertical tab, form feed, carriage return) may stand
// around dots but not inside a number. Octets wrap modulo 256. After the first
// error, or once four octets are complete, words are dropped until the
// newline. Error codes: 0 ok, 1 bad character, 2 number expected, 3 dot
// expected, 4 line ended early; the address is zero whenever the code is not
// zero. The input stalls only when a newline waits on a stalled result.
module ipv4_dotted_text_parser_top
   import ipv4dt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_address,
   output logic [2:0]  rsp_error_code
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // line state
   phase_type   phase_ff,   phase_in;
   logic [2:0]  octets_ff,  octets_in;
   logic [7:0]  octet_ff,   octet_in;
   logic [31:0] addr_ff,    addr_in;
   error_type   err_ff,     err_in;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   error_type   rsp_err_ff,  rsp_err_in;

   logic out_free;
   logic is_nl;
   logic proceed;
   logic take_req;

   // a held newline needs room in the result register; others always advance
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_nl    = (in_byte_ff == CHAR_NEWLINE);
   assign proceed  = in_valid_ff && (!is_nl || out_free);
   assign req_stall = in_valid_ff && !proceed;
   assign take_req  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (proceed) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_text_byte;
      end
   end

   // parse step
   always_comb begin
      phase_in    = phase_ff;
      octets_in   = octets_ff;
      octet_in    = octet_ff;
      addr_in     = addr_ff;
      err_in      = err_ff;
      rsp_addr_in = '0;
      rsp_err_in  = err_ff;
      if (is_nl) begin
         // close the line: a last octet still open completes the address
         if (err_ff == ERR_NONE) begin
            if ((phase_ff == PH_IN_NUMBER || phase_ff == PH_DOT_EXPECTED) &&
                octets_ff == LAST_OCTET_IDX) begin
               rsp_addr_in = put_octet(addr_ff, octets_ff[1:0], octet_ff);
            end else if (phase_ff == PH_COMPLETE) begin
               rsp_addr_in = addr_ff;
            end else begin
               rsp_err_in = ERR_SHORT;
            end
         end
         phase_in  = PH_NUM_EXPECTED;
         octets_in = '0;
         octet_in  = '0;
         addr_in   = '0;
         err_in    = ERR_NONE;
      end else if (err_ff == ERR_NONE && phase_ff != PH_COMPLETE) begin
         if (is_blank(in_byte_ff)) begin
            if (phase_ff == PH_IN_NUMBER) begin
               phase_in = PH_DOT_EXPECTED;
            end
         end else if (is_digit(in_byte_ff)) begin
            if (phase_ff == PH_NUM_EXPECTED) begin
               octet_in = in_byte_ff - CHAR_ZERO;
               phase_in = PH_IN_NUMBER;
            end else if (phase_ff == PH_IN_NUMBER) begin
               octet_in = acc_digit(octet_ff, in_byte_ff);
            end else begin
               err_in = ERR_DOT_EXP;
            end
         end else if (in_byte_ff == CHAR_DOT) begin
            if (phase_ff == PH_NUM_EXPECTED) begin
               err_in = ERR_NUM_EXP;
            end else begin
               addr_in   = put_octet(addr_ff, octets_ff[1:0], octet_ff);
               octets_in = octets_ff + 3'd1;
               octet_in  = '0;
               phase_in  = (octets_ff == LAST_OCTET_IDX) ? PH_COMPLETE
                                                          : PH_NUM_EXPECTED;
            end
         end else begin
            err_in = ERR_BAD_CHAR;
         end
      end
   end

   // advance line state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NUM_EXPECTED;
         octets_ff <= '0;
         octet_ff  <= '0;
         addr_ff   <= '0;
         err_ff    <= ERR_NONE;
      end else if (proceed) begin
         phase_ff  <= phase_in;
         octets_ff <= octets_in;
         octet_ff  <= octet_in;
         addr_ff   <= addr_in;
         err_ff    <= err_in;
      end
   end

   // result register: load on newline, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proceed && is_nl) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proceed && is_nl) begin
         rsp_addr_ff <= rsp_addr_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_address    = rsp_addr_ff;
   assign rsp_error_code = rsp_err_ff;

`ifndef SYNTH
   // a failed line never carries an address
   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff != ERR_NONE) |-> (rsp_addr_ff == '0))
      else $error("error result carries a nonzero address");

   // a newline leaves the line state cleared
   a_nl_clears: assert property (@(posedge clock) disable iff (reset)
      (proceed && is_nl) |=> (phase_ff == PH_NUM_EXPECTED && octets_ff == '0 &&
                              err_ff == ERR_NONE))
      else $error("line state not cleared after newline");

   // never more than four octets stored
   a_octet_count: assert property (@(posedge clock) disable iff (reset)
      octets_ff[2] |-> (octets_ff[1:0] == 2'd0 && phase_ff == PH_COMPLETE))
      else $error("octet count out of range");

   // a result waiting on a stall is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_addr_ff) &&
                                       $stable(rsp_err_ff)))
      else $error("stalled result changed");
`endif

endmodule

// File: test/ipv4dt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 dotted text parser checker
// Watches both channels, predicts the result of every text line from the
// accepted character words and compares each result field by field.
// ----------------------------------------------------------------------------
module ipv4dt_checker
   import ipv4dt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_address,
   input  logic [2:0]  rsp_error_code,
   output int unsigned fail_count,
   output int unsigned lines_pending
);

   typedef struct packed {
      logic [31:0] address;
      error_type   code;
   } line_result_type;

   line_result_type expected_lines[$];

   // line state of the predictor
   phase_type   phase       = PH_NUM_EXPECTED;
   logic [2:0]  octet_count = 3'd0;
   logic [7:0]  octet_acc   = 8'd0;
   logic [31:0] addr_acc    = 32'd0;
   error_type   first_error = ERR_NONE;
   int unsigned mismatches  = 0;

   function automatic void clear_line();
      phase       = PH_NUM_EXPECTED;
      octet_count = 3'd0;
      octet_acc   = 8'd0;
      addr_acc    = 32'd0;
      first_error = ERR_NONE;
   endfunction

   function automatic void store_octet_value();
      addr_acc    = addr_acc |
                    ({24'd0, octet_acc} << (8 * (3 - int'(octet_count[1:0]))));
      octet_count = octet_count + 3'd1;
      octet_acc   = 8'd0;
   endfunction

   // advance the line by one character; return 1 when a newline closes it
   function automatic logic parse_char(input logic [7:0] ch,
                                       output line_result_type res);
      res.address = 32'd0;
      res.code    = first_error;
      if (ch == CHAR_NEWLINE) begin
         if (first_error == ERR_NONE) begin
            // a fourth number ended by the newline itself still counts
            if ((phase == PH_IN_NUMBER || phase == PH_DOT_EXPECTED) &&
                octet_count == LAST_OCTET_IDX) begin
               store_octet_value();
               phase = PH_COMPLETE;
            end
            if (phase == PH_COMPLETE) res.address = addr_acc;
            else res.code = ERR_SHORT;
         end
         clear_line();
         return 1'b1;
      end
      // drop everything after an error or a complete address
      if (first_error != ERR_NONE || phase == PH_COMPLETE) return 1'b0;
      if (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_VTAB ||
          ch == CHAR_FFEED || ch == CHAR_CRET) begin
         if (phase == PH_IN_NUMBER) phase = PH_DOT_EXPECTED;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         if (phase == PH_NUM_EXPECTED) begin
            octet_acc = ch - CHAR_ZERO;
            phase     = PH_IN_NUMBER;
         end else if (phase == PH_IN_NUMBER) begin
            octet_acc = 8'(octet_acc * 8'd10 + (ch - CHAR_ZERO));
         end else begin
            first_error = ERR_DOT_EXP;
         end
      end else if (ch == CHAR_DOT) begin
         if (phase == PH_NUM_EXPECTED) begin
            first_error = ERR_NUM_EXP;
         end else begin
            store_octet_value();
            phase = (octet_count >= OCTETS_PER_ADDR) ? PH_COMPLETE : PH_NUM_EXPECTED;
         end
      end else begin
         first_error = ERR_BAD_CHAR;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      line_result_type res;
      line_result_type want;
      if (reset) begin
         clear_line();
         expected_lines.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               $error("unexpected result: address %h error_code %0d",
                      rsp_address, rsp_error_code);
               mismatches++;
            end else begin
               want = expected_lines.pop_front();
               if (rsp_address !== want.address) begin
                  $error("address mismatch: expected %h, actual %h",
                         want.address, rsp_address);
                  mismatches++;
               end
               if (rsp_error_code !== want.code) begin
                  $error("error_code mismatch: expected %0d, actual %0d",
                         want.code, rsp_error_code);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (parse_char(req_text_byte, res)) expected_lines.push_back(res);
         end
      end
      fail_count    <= mismatches;
      lines_pending <= expected_lines.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 dotted text parser testbench
// Feeds text lines to the parser with random gaps and result stalls, one
// long result hold-off included; a checker beside the block predicts and
// compares every line result.
// ----------------------------------------------------------------------------
module testbench;
   import ipv4dt_pkg::*;

   localparam int TEXT_WORDS   = 1600;   // stop adding lines past this size
   localparam int MAX_GAP      = 12;     // longest idle per word, either side
   localparam int HOLD_AT_LINE = 40;     // results taken before the long hold
   localparam int HOLD_CYCLES  = 400;    // long result hold-off
   localparam int DRAIN_CYCLES = 8;      // extra wait after the last result is checked
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_text_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_address;
   logic [2:0]  rsp_error_code;
   int unsigned fail_count;
   int unsigned lines_pending;

   // whole text stream, and the line under construction
   logic [7:0] text_q[$];
   logic [7:0] line_q[$];

   ipv4_dotted_text_parser_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_address    (rsp_address),
      .rsp_error_code (rsp_error_code)
   );

   ipv4dt_checker line_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_address    (rsp_address),
      .rsp_error_code (rsp_error_code),
      .fail_count     (fail_count),
      .lines_pending  (lines_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hold reset at the start, once
   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 4))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_VTAB;
         3:       return CHAR_FFEED;
         default: return CHAR_CRET;
      endcase
   endfunction

   function automatic logic [7:0] pick_non_newline();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_NEWLINE);
      return b;
   endfunction

   // compose a well-formed address line, without its newline, in line_q:
   // random digit counts (wrapping values too), blanks around the dots and
   // several ways to end the fourth number
   function automatic void build_address();
      line_q.delete();
      for (int k = 0; k < 4; k++) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) line_q.push_back(pick_blank());
         if ($urandom_range(0, 15) == 0) begin
            line_q.push_back(8'h32);
            line_q.push_back(8'h35);
            line_q.push_back(8'h35);
         end else begin
            repeat (($urandom_range(0, 7) == 0) ? 4 : $urandom_range(1, 3))
               line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) line_q.push_back(pick_blank());
         if (k < 3) line_q.push_back(CHAR_DOT);
      end
      case ($urandom_range(0, 3))
         0: repeat ($urandom_range(1, 3)) line_q.push_back(pick_blank());
         1: begin
            // dot after the fourth number, then junk that must be dropped
            line_q.push_back(CHAR_DOT);
            repeat ($urandom_range(0, 3)) line_q.push_back(pick_non_newline());
         end
         default: ;
      endcase
   endfunction

   // damage line_q at a random spot: cut it short, or insert a stray
   // character, an extra dot, or a digit after a blank
   function automatic void break_line();
      int unsigned pos;
      pos = $urandom_range(0, line_q.size());
      case ($urandom_range(0, 3))
         0: while (line_q.size() > pos) void'(line_q.pop_back());
         1: line_q.insert(pos, pick_non_newline());
         2: line_q.insert(pos, CHAR_DOT);
         default: begin
            line_q.insert(pos, 8'(CHAR_ZERO + $urandom_range(0, 9)));
            line_q.insert(pos, pick_blank());
         end
      endcase
   endfunction

   // Sender: build the whole text first, then offer one word at a time.
   initial begin : sender
      string       directed;
      int unsigned kind;
      int unsigned gap;
      bit          burst;
      req_valid     = 1'b0;
      req_text_byte = 8'd0;
      burst         = 1'b0;

      // Directed lines: empty line, dot with no number, digit after blanks
      // with a later bad character (first error wins), a lone 0xff byte,
      // then a wrapping first octet, blanks around dots and a dot after the
      // fourth number followed by junk.
      directed = "\n.\n1 2x\n\377\n999 .0.\t9.1.z\n";
      for (int i = 0; i < directed.len(); i++) text_q.push_back(directed[i]);

      // Random lines: mostly well-formed, some damaged, some pure noise
      // over the full byte range.
      while (text_q.size() < TEXT_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_address();
            if (kind < 35) break_line();
            foreach (line_q[i]) text_q.push_back(line_q[i]);
         end
         text_q.push_back(CHAR_NEWLINE);
      end

      @(posedge clock);
      while (reset) @(posedge clock);

      while (text_q.size() > 0) begin
         // switch now and then between random gaps and back-to-back words
         if ($urandom_range(0, 31) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_text_byte <= text_q.pop_front();
         // hold the word until the block takes it
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;

      // let the checker record the last word, then drain
      @(posedge clock);
      while (lines_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Receiver: stall a random number of cycles before each result; once,
   // hold off long enough that a newline backs up and stalls the input.
   initial begin : receiver
      int unsigned taken;
      int unsigned hold;
      bit          burst;
      rsp_stall = 1'b0;
      taken     = 0;
      burst     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) burst = !burst;
         if (taken == HOLD_AT_LINE) hold = HOLD_CYCLES;
         else hold = burst ? 0 : $urandom_range(0, MAX_GAP);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // wait for the next result to be taken
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule
